FILE: hdl/rgblap_pkg.sv
// ----------------------------------------------------------------------------
// rgblap_pkg
// Shared types, register codes and the per-channel Laplacian kernel.
// ----------------------------------------------------------------------------
package rgblap_pkg;

    localparam int FIFO_DEPTH = 4;

    localparam logic [0:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [0:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [9:0] FRAME_WIDTH_RST  = 10'd480;
    localparam logic [9:0] FRAME_HEIGHT_RST = 10'd270;

    localparam logic [1:0] CH_BLUE  = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_RED   = 2'd2;

    typedef logic [23:0] pixel_t;

    // [row 0 = top][col 0 = left]
    typedef pixel_t [2:0][2:0] window_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [8:0] col;
        logic [8:0] row;
        logic       last;
    } result_t;

    // 8 * centre minus the eight neighbours, clamped to 0..255
    function automatic logic [7:0] lap_chan(window_t win, logic [1:0] ch);
        logic [10:0] nsum;
        logic [11:0] acc;
        logic [4:0]  sh;
        logic [7:0]  res;
        nsum = '0;
        sh   = {ch, 3'b000};
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (!(i == 1 && j == 1))
                begin
                    nsum = nsum + {3'b000, win[i][j][sh +: 8]};
                end
            end
        end
        acc = {1'b0, win[1][1][sh +: 8], 3'b000} - {1'b0, nsum};
        if (acc[11])
        begin
            res = 8'd0;
        end
        else if (acc[10:8] != 3'd0)
        begin
            res = 8'd255;
        end
        else
        begin
            res = acc[7:0];
        end
        return res;
    endfunction

endpackage

FILE: hdl/rgblap_line_store.sv
// ----------------------------------------------------------------------------
// rgblap_line_store
// Upper and lower line memories, one write and one registered read port each.
// ----------------------------------------------------------------------------
module rgblap_line_store
    import rgblap_pkg::*;
#(
    parameter int DEPTH = 512,
    parameter int AW    = 9
)
(
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output pixel_t        rd_upper,
    output pixel_t        rd_lower,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  pixel_t        wr_upper,
    input  pixel_t        wr_lower
);

    pixel_t upper_mem [0:DEPTH-1];
    pixel_t lower_mem [0:DEPTH-1];
    pixel_t rd_upper_reg;
    pixel_t rd_lower_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_upper_reg <= upper_mem[rd_addr];
            rd_lower_reg <= lower_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            upper_mem[wr_addr] <= wr_upper;
            lower_mem[wr_addr] <= wr_lower;
        end
    end

    assign rd_upper = rd_upper_reg;
    assign rd_lower = rd_lower_reg;

endmodule

FILE: hdl/rgblap_out_fifo.sv
// ----------------------------------------------------------------------------
// rgblap_out_fifo
// Small result queue between the kernel and the output channel.
// ----------------------------------------------------------------------------
module rgblap_out_fifo
    import rgblap_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  result_t    push_data,
    input  logic       pop,
    output logic       not_empty,
    output result_t    head,
    output logic [2:0] count
);

    localparam int PW = $clog2(FIFO_DEPTH);

    result_t       buf_mem [0:FIFO_DEPTH-1];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [2:0]    count_reg;
    logic [2:0]    count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 3'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

    assign not_empty = (count_reg != 3'd0);
    assign head      = buf_mem[rd_ptr_reg];
    assign count     = count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < 3'(FIFO_DEPTH)))
        else $error("result queue overflow");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != 3'd0))
        else $error("result queue underflow");

endmodule

FILE: hdl/rgb_laplacian_edge_filter.sv
// ----------------------------------------------------------------------------
// rgb_laplacian_edge_filter
// Streaming 3x3 Laplacian edge filter on RGB pixels in raster order.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry one pixel per request, with
// frame_start marking column 0, row 0. Output channel: out_valid / out_stall
// carry one result per interior pixel: clamped 8*centre minus neighbours per
// channel, with its column, row and a frame_last flag. Border pixels produce
// nothing; the host keeps them.
// Throughput: one pixel per cycle while in_stall is low. Each request reads both
// line memories at its column and writes them back in the next cycle, a forward
// covering a repeat of the same column on back-to-back requests.
// A request that completes a window (the lower-right neighbour) passes stage 1,
// then the window and stage 2 registers and the result queue before it is visible.
// A four-entry result queue absorbs receiver stalls; in_stall rises once the
// queue plus the two pipeline stages could fill it.
// Reset clears position counters, window and queue and loads width 480 and
// height 270; the line memories are not cleared and need no clearing pass.
// cfg_wr_en writes frame_width (index 0) or frame_height (index 1); the user must write only while idle (unenforced).
// ----------------------------------------------------------------------------
module rgb_laplacian_edge_filter
    import rgblap_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [0:0] cfg_index,
    input  logic [9:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] red_in,
    input  logic [7:0] green_in,
    input  logic [7:0] blue_in,
    input  logic       frame_start,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] red_out,
    output logic [7:0] green_out,
    output logic [7:0] blue_out,
    output logic [8:0] col_out,
    output logic [8:0] row_out,
    output logic       frame_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [9:0]    frame_width_reg;
    logic [9:0]    frame_height_reg;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;

    logic [CW-1:0] w_last;
    logic [RW-1:0] h_last;
    logic [CW-1:0] col_pre;
    logic [RW-1:0] row_pre;
    logic [CW-1:0] c;
    logic [RW:0]   r1;
    logic [RW-1:0] r;
    logic          in_acc;

    logic          s1_vld_reg;
    pixel_t        s1_px_reg;
    logic [CW-1:0] s1_col_reg;
    logic          s1_emit_reg;
    logic          s1_last_reg;
    logic [8:0]    s1_cout_reg;
    logic [8:0]    s1_rout_reg;

    logic          s2_vld_reg;
    pixel_t        s2_px_reg;
    pixel_t        s2_lo_reg;
    logic [CW-1:0] s2_col_reg;
    logic          s2_emit_reg;
    logic          s2_last_reg;
    logic [8:0]    s2_cout_reg;
    logic [8:0]    s2_rout_reg;

    window_t       win_reg;
    pixel_t        rd_upper;
    pixel_t        rd_lower;
    pixel_t        up_fwd;
    pixel_t        lo_fwd;
    logic          fwd;

    logic          fifo_push;
    logic          fifo_pop;
    result_t       push_data;
    result_t       head;
    logic [2:0]    fifo_count;
    logic [2:0]    occupancy;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        if (frame_width_reg < 10'd3)
        begin
            w_last = CW'(2);
        end
        else if (32'(frame_width_reg) > MAX_WIDTH)
        begin
            w_last = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            w_last = CW'(frame_width_reg - 10'd1);
        end

        if (frame_height_reg < 10'd3)
        begin
            h_last = RW'(2);
        end
        else if (32'(frame_height_reg) > MAX_HEIGHT)
        begin
            h_last = RW'(MAX_HEIGHT - 1);
        end
        else
        begin
            h_last = RW'(frame_height_reg - 10'd1);
        end
    end

    // position of the incoming pixel
    assign in_acc  = in_valid && !in_stall;
    assign col_pre = frame_start ? '0 : col_reg;
    assign row_pre = frame_start ? '0 : row_reg;

    always_comb
    begin
        if (col_pre > w_last)
        begin
            c  = '0;
            r1 = {1'b0, row_pre} + (RW+1)'(1);
        end
        else
        begin
            c  = col_pre;
            r1 = {1'b0, row_pre};
        end
        r = (r1 > {1'b0, h_last}) ? '0 : r1[RW-1:0];

        if (c == w_last)
        begin
            col_next = '0;
            row_next = (r == h_last) ? '0 : r + RW'(1);
        end
        else
        begin
            col_next = c + CW'(1);
            row_next = r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            win_reg    <= '0;
        end
        else
        begin
            if (in_acc)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            s1_vld_reg <= in_acc;
            s2_vld_reg <= s1_vld_reg;
            if (s1_vld_reg)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[i][0] <= win_reg[i][1];
                    win_reg[i][1] <= win_reg[i][2];
                end
                win_reg[0][2] <= up_fwd;
                win_reg[1][2] <= lo_fwd;
                win_reg[2][2] <= s1_px_reg;
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_px_reg   <= {red_in, green_in, blue_in};
            s1_col_reg  <= c;
            s1_emit_reg <= (c > CW'(1)) && (r > RW'(1));
            s1_last_reg <= (c == w_last) && (r == h_last);
            s1_cout_reg <= 9'(c - CW'(1));
            s1_rout_reg <= 9'(r - RW'(1));
        end
        if (s1_vld_reg)
        begin
            s2_px_reg   <= s1_px_reg;
            s2_lo_reg   <= lo_fwd;
            s2_col_reg  <= s1_col_reg;
            s2_emit_reg <= s1_emit_reg;
            s2_last_reg <= s1_last_reg;
            s2_cout_reg <= s1_cout_reg;
            s2_rout_reg <= s1_rout_reg;
        end
    end

    // previous request wrote this column on the same edge as our read
    assign fwd    = s2_vld_reg && (s2_col_reg == s1_col_reg);
    assign up_fwd = fwd ? s2_lo_reg : rd_upper;
    assign lo_fwd = fwd ? s2_px_reg : rd_lower;

    rgblap_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_store (
        .clk      (clk),
        .rd_en    (in_acc),
        .rd_addr  (c),
        .rd_upper (rd_upper),
        .rd_lower (rd_lower),
        .wr_en    (s1_vld_reg),
        .wr_addr  (s1_col_reg),
        .wr_upper (lo_fwd),
        .wr_lower (s1_px_reg)
    );

    // kernel
    always_comb
    begin
        push_data.red   = lap_chan(win_reg, CH_RED);
        push_data.green = lap_chan(win_reg, CH_GREEN);
        push_data.blue  = lap_chan(win_reg, CH_BLUE);
        push_data.col   = s2_cout_reg;
        push_data.row   = s2_rout_reg;
        push_data.last  = s2_last_reg;
    end

    assign fifo_push = s2_vld_reg && s2_emit_reg;
    assign fifo_pop  = out_valid && !out_stall;

    rgblap_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .push_data (push_data),
        .pop       (fifo_pop),
        .not_empty (out_valid),
        .head      (head),
        .count     (fifo_count)
    );

    assign occupancy = fifo_count + {2'b00, s1_vld_reg} + {2'b00, s2_vld_reg};
    assign in_stall  = (occupancy >= 3'(FIFO_DEPTH));

    assign red_out    = head.red;
    assign green_out  = head.green;
    assign blue_out   = head.blue;
    assign col_out    = head.col;
    assign row_out    = head.row;
    assign frame_last = head.last;

    a_pipe_advance: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (s1_vld_reg ##1 s2_vld_reg))
        else $error("request lost in pipeline");

    a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_push |-> (s2_cout_reg != 9'd0 && s2_rout_reg != 9'd0))
        else $error("border pixel emitted");

endmodule

FILE: sim/tb_rgb_laplacian_edge_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_laplacian_edge_filter
// Streams RGB frames through the Laplacian edge filter and checks every
// interior result against a behavioural copy of the line stores and window.
// A short table of hand-checked frames comes first, then frames of random
// size and texture, plus one long-row frame and part of a frame at the
// tallest size.
// Both channels idle and stall at random in the first two of three stretches.
// ----------------------------------------------------------------------------
module tb_rgb_laplacian_edge_filter;
    import rgblap_pkg::*;

    localparam int MAX_DIM       = 512;
    localparam int WIDE_DIM      = 160;
    localparam int TALL_ROWS     = 40;
    localparam int RANDOM_PIXELS = 480;
    localparam result_t NO_RESULT = '0;

    typedef enum int {TEXTURE_NOISE, TEXTURE_SMOOTH, TEXTURE_BINARY} texture_e;

    typedef struct packed {
        logic       fs;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       typed;
        result_t    want;
    } stim_row_t;

    logic       clk;
    logic       rst_n       = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [0:0] cfg_index   = REG_FRAME_WIDTH;
    logic [9:0] cfg_data    = '0;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    logic [7:0] red_in      = '0;
    logic [7:0] green_in    = '0;
    logic [7:0] blue_in     = '0;
    logic       frame_start = 1'b0;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [8:0] col_out;
    logic [8:0] row_out;
    logic       frame_last;

    // two junk pixels, a restart mid-row, then two 3x3 frames (the second
    // relies on the counters wrapping, no frame_start)
    stim_row_t directed_rows [20] = '{
        '{1'b1, 8'h5A, 8'hA5, 8'h3C, 1'b0, NO_RESULT},
        '{1'b0, 8'hC3, 8'h0F, 8'hF0, 1'b0, NO_RESULT},
        '{1'b1, 8'd0,   8'd255, 8'd10,  1'b0, NO_RESULT},
        '{1'b0, 8'd0,   8'd255, 8'd10,  1'b0, NO_RESULT},
        '{1'b0, 8'd0,   8'd255, 8'd10,  1'b0, NO_RESULT},
        '{1'b0, 8'd0,   8'd255, 8'd10,  1'b0, NO_RESULT},
        '{1'b0, 8'd255, 8'd0,   8'd40,  1'b0, NO_RESULT},
        '{1'b0, 8'd0,   8'd255, 8'd10,  1'b0, NO_RESULT},
        '{1'b0, 8'd0,   8'd255, 8'd10,  1'b0, NO_RESULT},
        '{1'b0, 8'd0,   8'd255, 8'd10,  1'b0, NO_RESULT},
        '{1'b0, 8'd0,   8'd255, 8'd10,  1'b1, '{8'd255, 8'd0, 8'd240, 9'd1, 9'd1, 1'b1}},
        '{1'b0, 8'd255, 8'd0,   8'd223, 1'b0, NO_RESULT},
        '{1'b0, 8'd255, 8'd0,   8'd223, 1'b0, NO_RESULT},
        '{1'b0, 8'd255, 8'd0,   8'd223, 1'b0, NO_RESULT},
        '{1'b0, 8'd255, 8'd0,   8'd223, 1'b0, NO_RESULT},
        '{1'b0, 8'd0,   8'd255, 8'd255, 1'b0, NO_RESULT},
        '{1'b0, 8'd255, 8'd0,   8'd223, 1'b0, NO_RESULT},
        '{1'b0, 8'd255, 8'd0,   8'd223, 1'b0, NO_RESULT},
        '{1'b0, 8'd255, 8'd0,   8'd223, 1'b0, NO_RESULT},
        '{1'b0, 8'd255, 8'd0,   8'd223, 1'b1, '{8'd0, 8'd255, 8'd255, 9'd1, 9'd1, 1'b1}}
    };

    int send_gap_pct [3] = '{15, 63, 0};
    int recv_gap_pct [3] = '{63, 15, 0};
    int idle_phase       = 0;

    // filter state as the block should hold it
    logic [9:0] cfg_width  = FRAME_WIDTH_RST;
    logic [9:0] cfg_height = FRAME_HEIGHT_RST;
    pixel_t     upper_line [MAX_DIM] = '{default: '0};
    pixel_t     lower_line [MAX_DIM] = '{default: '0};
    pixel_t     win_px [3][3]        = '{default: '{default: '0}};
    int         col_pos = 0;
    int         row_pos = 0;

    result_t expected_edges [$];
    int      pixels_sent   = 0;
    int      edges_checked = 0;
    int      frames_closed = 0;
    int      size_settings = 0;
    int      mismatches    = 0;

    rgb_laplacian_edge_filter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out),
        .col_out     (col_out),
        .row_out     (row_out),
        .frame_last  (frame_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("rgb_laplacian_edge_filter regression: fail");
        $finish;
    end

    function automatic int clamp_dim(input logic [9:0] v);
        if (v < 3)
            return 3;
        if (v > MAX_DIM)
            return MAX_DIM;
        return int'(v);
    endfunction

    // 9*centre minus all nine taps = 8*centre minus the eight neighbours
    function automatic logic [7:0] edge_chan(input int lsb);
        int acc;
        acc = 9 * int'(win_px[1][1][lsb +: 8]);
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                acc -= int'(win_px[i][j][lsb +: 8]);
            end
        end
        if (acc < 0)
            return 8'd0;
        if (acc > 255)
            return 8'd255;
        return 8'(acc);
    endfunction

    task automatic predict_edge_pixel(input pixel_t px, input logic fs,
                                      output logic hit, output result_t res);
        int     w;
        int     h;
        int     c;
        int     r;
        pixel_t up;
        pixel_t lo;
        w = clamp_dim(cfg_width);
        h = clamp_dim(cfg_height);
        if (fs)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        // size may have shrunk under the counters
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h)
            row_pos = 0;
        c  = col_pos;
        r  = row_pos;
        up = upper_line[c];
        lo = lower_line[c];
        for (int i = 0; i < 3; i++)
        begin
            win_px[i][0] = win_px[i][1];
            win_px[i][1] = win_px[i][2];
        end
        win_px[0][2]  = up;
        win_px[1][2]  = lo;
        win_px[2][2]  = px;
        upper_line[c] = lo;
        lower_line[c] = px;
        hit = (c >= 2 && r >= 2);
        res = NO_RESULT;
        if (hit)
            res = {edge_chan(16), edge_chan(8), edge_chan(0), 9'(c - 1), 9'(r - 1),
                   1'(c == w - 1 && r == h - 1)};
        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
        end
    endtask

    task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic fs, input logic typed, input result_t typed_res);
        logic    hit;
        result_t res;
        idle_phase = (pixels_sent < 380) ? 0 : (pixels_sent < 760) ? 1 : 2;
        while ($urandom_range(0, 99) < send_gap_pct[idle_phase])
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        red_in      <= r;
        green_in    <= g;
        blue_in     <= b;
        frame_start <= fs;
        do
            @(posedge clk);
        while (in_stall);
        pixels_sent++;
        predict_edge_pixel({r, g, b}, fs, hit, res);
        if (typed)
            expected_edges.push_back(typed_res);
        else if (hit)
            expected_edges.push_back(res);
    endtask

    task automatic set_frame_size(input logic [9:0] w, input logic [9:0] h);
        in_valid <= 1'b0;
        while (expected_edges.size() != 0)
            @(posedge clk);
        // let a request that yields no result drain from the pipeline
        repeat (4) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        cfg_width  = w;
        cfg_height = h;
        size_settings++;
    endtask

    function automatic logic [7:0] shade(input texture_e tex, input int base);
        case (tex)
            TEXTURE_NOISE:  return 8'($urandom_range(0, 255));
            TEXTURE_SMOOTH: return 8'(base + $urandom_range(0, 25));
            default:        return $urandom_range(0, 1) ? 8'd255 : 8'd0;
        endcase
    endfunction

    task automatic stream_frame(input int n_px, input logic lead_fs, input texture_e tex,
                                input logic noisy);
        int   base;
        logic fs;
        base = $urandom_range(0, 230);
        for (int k = 0; k < n_px; k++)
        begin
            fs = (k == 0) ? lead_fs : (noisy && $urandom_range(0, 149) == 0);
            push_pixel(shade(tex, base), shade(tex, base), shade(tex, base), fs,
                       1'b0, NO_RESULT);
        end
    endtask

    // result side
    initial
    begin
        result_t seen;
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                seen = {red_out, green_out, blue_out, col_out, row_out, frame_last};
                if (expected_edges.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: expected no result, got col %0d row %0d", $time,
                             col_out, row_out);
                end
                else
                begin
                    want = expected_edges.pop_front();
                    edges_checked++;
                    if (seen.last)
                        frames_closed++;
                    if (seen !== want)
                    begin
                        mismatches++;
                        $display({"%0t: expected rgb %0d/%0d/%0d col %0d row %0d last %0d",
                                  ", got rgb %0d/%0d/%0d col %0d row %0d last %0d"},
                                 $time, want.red, want.green, want.blue, want.col,
                                 want.row, want.last, seen.red, seen.green, seen.blue,
                                 seen.col, seen.row, seen.last);
                    end
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_gap_pct[idle_phase]);
        end
    end

    // request side
    initial
    begin
        int         random_pixels;
        int         phase_no;
        int         n_frames;
        int         area;
        int         n_px;
        logic [9:0] new_w;
        logic [9:0] new_h;
        logic       lead;
        random_pixels = 0;
        phase_no      = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        set_frame_size(10'd3, 10'd3);
        foreach (directed_rows[i])
            push_pixel(directed_rows[i].red, directed_rows[i].green, directed_rows[i].blue,
                       directed_rows[i].fs, directed_rows[i].typed, directed_rows[i].want);

        while (random_pixels < RANDOM_PIXELS)
        begin
            if (phase_no == 1)
            begin
                set_frame_size(10'(WIDE_DIM), 10'd0);
                stream_frame(WIDE_DIM * 3, 1'b1, TEXTURE_SMOOTH, 1'b0);
            end
            else if (phase_no == 2)
            begin
                set_frame_size(10'd1, 10'd1023);
                stream_frame(3 * TALL_ROWS, 1'b1, TEXTURE_NOISE, 1'b0);
            end
            else
            begin
                new_w = 10'($urandom_range(0, 14));
                new_h = 10'($urandom_range(0, 9));
                // a wider row would read columns never filled: restart the frame
                lead  = (clamp_dim(new_w) > clamp_dim(cfg_width)) || $urandom_range(0, 1);
                set_frame_size(new_w, new_h);
                n_frames = $urandom_range(1, 3);
                area     = clamp_dim(new_w) * clamp_dim(new_h);
                for (int f = 0; f < n_frames; f++)
                begin
                    n_px = ($urandom_range(0, 9) == 0) ? $urandom_range(1, area - 1) : area;
                    stream_frame(n_px, (f == 0) ? lead : ($urandom_range(0, 3) != 0),
                                 texture_e'($urandom_range(0, 2)), 1'b1);
                    random_pixels += n_px;
                end
            end
            phase_no++;
        end

        in_valid <= 1'b0;
        while (expected_edges.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        $display("%0d pixels over %0d frame sizes, widths 3..%0d and heights 3..512",
                 pixels_sent, size_settings, WIDE_DIM);
        $display("%0d edge results checked, %0d frame ends seen", edges_checked,
                 frames_closed);
        if (mismatches == 0)
            $display("rgb_laplacian_edge_filter regression: pass");
        else
            $display("rgb_laplacian_edge_filter regression: fail");
        $finish;
    end

endmodule
